>>> rtl/kcmm_pkg.sv
`timescale 1ns / 1ps

package kcmm_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_BITS   = 32;
  localparam int COUNT_BITS = 32;
  localparam int FIELD_BITS = 32;
  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int ADDR_BITS  = IDX_BITS + 1;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [FIELD_BITS-1:0] field_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;

  localparam count_t COUNT_MAX = '1;
  localparam count_t COUNT_ONE = count_t'(1);
  localparam addr_t  ADDR_END  = addr_t'(CAPACITY);

  typedef enum logic {
    OP_INC = 1'b0,
    OP_DEC = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_ABSENT = 2'd2
  } status_t;

  typedef struct packed {
    status_t status;
    logic    is_empty;
    field_t  max_key;
    field_t  max_count;
    field_t  min_key;
    field_t  min_count;
  } result_t;

endpackage

>>> rtl/kcmm_if.sv
`timescale 1ns / 1ps

interface kcmm_in_if;
  import kcmm_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  field_t  key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink (input valid, input opcode, input key, output ready);
endinterface

interface kcmm_out_if;
  import kcmm_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  logic    is_empty;
  field_t  max_key;
  field_t  max_count;
  field_t  min_key;
  field_t  min_count;

  modport source (output valid, output status, output is_empty, output max_key,
                  output max_count, output min_key, output min_count, input ready);
  modport sink (input valid, input status, input is_empty, input max_key,
                input max_count, input min_key, input min_count, output ready);
endinterface

>>> rtl/kcmm_engine.sv
`timescale 1ns / 1ps

module kcmm_engine (
  input  logic              clk,
  input  logic              rst_n,
  kcmm_in_if.sink           in_if,
  output kcmm_pkg::result_t res_o,
  output logic              res_valid_o,
  input  logic              res_ready_i
);
  import kcmm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic   any;
    key_t   mxk;
    count_t mxc;
    key_t   mnk;
    count_t mnc;
  } minmax_t;

  function automatic minmax_t fold(minmax_t a, key_t k, count_t c);
    minmax_t r;
    r = a;
    if (!a.any) begin
      r.any = 1'b1;
      r.mxk = k;
      r.mxc = c;
      r.mnk = k;
      r.mnc = c;
    end else begin
      if (c > a.mxc || (c == a.mxc && k > a.mxk)) begin
        r.mxk = k;
        r.mxc = c;
      end
      if (c < a.mnc || (c == a.mnc && k < a.mnk)) begin
        r.mnk = k;
        r.mnc = c;
      end
    end
    return r;
  endfunction

  function automatic count_t sat_inc(count_t c);
    return (c == COUNT_MAX) ? c : c + COUNT_ONE;
  endfunction

  key_t   key_mem [CAPACITY];
  count_t cnt_mem [CAPACITY];

  state_t              state_r, state_nxt;
  addr_t               rd_addr_r, rd_addr_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [CAPACITY-1:0] valid_r, valid_nxt;

  opcode_t op_r;
  key_t    key_r;
  logic    rd_vld_r;
  key_t    key_rd_r;
  count_t  cnt_rd_r;
  idx_t    rd_idx_r;
  minmax_t acc_r, acc_nxt;
  logic    hit_r;
  idx_t    hit_idx_r;
  count_t  hit_cnt_r;
  logic    free_found_r;
  idx_t    free_idx_r;

  logic    accept;
  logic    commit;
  logic    elem_match;
  logic    elem_use;
  count_t  elem_cnt;
  logic    new_entry;
  logic    cnt_we;
  logic    key_we;
  idx_t    wr_idx;
  count_t  wr_cnt;
  minmax_t fin;
  status_t status;

  assign in_if.ready = (state_r == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign res_valid_o = (state_r == ST_DONE);
  assign commit      = res_valid_o && res_ready_i;

  // One table entry arrives from the memories per cycle; the entry holding the
  // key is folded in with its updated count, and a freed entry is left out.
  always_comb begin
    elem_match = rd_vld_r && (key_rd_r == key_r);
    elem_cnt   = cnt_rd_r;
    elem_use   = rd_vld_r;
    if (elem_match) begin
      if (op_r == OP_INC) begin
        elem_cnt = sat_inc(cnt_rd_r);
      end else begin
        elem_cnt = cnt_rd_r - COUNT_ONE;
        elem_use = (cnt_rd_r > COUNT_ONE);
      end
    end
    acc_nxt = elem_use ? fold(acc_r, key_rd_r, elem_cnt) : acc_r;
  end

  always_comb begin
    new_entry = (op_r == OP_INC) && !hit_r && free_found_r;
    fin       = new_entry ? fold(acc_r, key_r, COUNT_ONE) : acc_r;
    key_we    = new_entry;
    cnt_we    = hit_r || new_entry;
    wr_idx    = hit_r ? hit_idx_r : free_idx_r;
    if (op_r == OP_INC) begin
      wr_cnt = hit_r ? sat_inc(hit_cnt_r) : COUNT_ONE;
      status = (hit_r || free_found_r) ? STATUS_DONE : STATUS_FULL;
    end else begin
      wr_cnt = hit_cnt_r - COUNT_ONE;
      status = hit_r ? STATUS_DONE : STATUS_ABSENT;
    end
  end

  assign res_o.status    = status;
  assign res_o.is_empty  = !fin.any;
  assign res_o.max_key   = fin.any ? field_t'(fin.mxk) : '0;
  assign res_o.max_count = fin.any ? field_t'(fin.mxc) : '0;
  assign res_o.min_key   = fin.any ? field_t'(fin.mnk) : '0;
  assign res_o.min_count = fin.any ? field_t'(fin.mnc) : '0;

  always_comb begin
    state_nxt   = state_r;
    rd_addr_nxt = rd_addr_r;
    rd_pend_nxt = 1'b0;
    valid_nxt   = valid_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt   = ST_SCAN;
          rd_addr_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (rd_addr_r != ADDR_END) begin
          rd_pend_nxt = 1'b1;
          rd_addr_nxt = rd_addr_r + addr_t'(1);
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_nxt = ST_IDLE;
          if (new_entry) begin
            valid_nxt[free_idx_r] = 1'b1;
          end else if (op_r == OP_DEC && hit_r && hit_cnt_r <= COUNT_ONE) begin
            valid_nxt[hit_idx_r] = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_addr_r <= '0;
      rd_pend_r <= 1'b0;
      valid_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_addr_r <= rd_addr_nxt;
      rd_pend_r <= rd_pend_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && key_we) begin
      key_mem[wr_idx] <= key_r;
    end
    if (commit && cnt_we) begin
      cnt_mem[wr_idx] <= wr_cnt;
    end
    key_rd_r <= key_mem[rd_addr_r[IDX_BITS-1:0]];
    cnt_rd_r <= cnt_mem[rd_addr_r[IDX_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_addr_r[IDX_BITS-1:0];
    rd_vld_r <= valid_r[rd_addr_r[IDX_BITS-1:0]];
    if (accept) begin
      op_r         <= in_if.opcode;
      key_r        <= key_t'(in_if.key);
      acc_r.any    <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
    end else if (rd_pend_r) begin
      acc_r <= acc_nxt;
      if (elem_match) begin
        hit_r     <= 1'b1;
        hit_idx_r <= rd_idx_r;
        hit_cnt_r <= cnt_rd_r;
      end
      if (!rd_vld_r && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
    end
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SCAN && rd_addr_r == '0))
    else $error("accepted word did not start a table sweep");

  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_addr_r <= ADDR_END)
    else $error("sweep address ran past the table");

  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> state_r == ST_SCAN)
    else $error("memory read data pending outside the sweep");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !res_ready_i) |=> state_r == ST_DONE)
    else $error("result left before it was taken");

  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (state_r == ST_IDLE && !rd_pend_r))
    else $error("block not idle after write-back");

endmodule

>>> rtl/kcmm_out_reg.sv
`timescale 1ns / 1ps

module kcmm_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  kcmm_pkg::result_t res_i,
  input  logic              res_valid_i,
  output logic              res_ready_o,
  kcmm_out_if.source        out_if
);
  import kcmm_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign res_ready_o = !valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready_o) begin
      valid_r <= res_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready_o && res_valid_i) begin
      data_r <= res_i;
    end
  end

  assign out_if.valid     = valid_r;
  assign out_if.status    = data_r.status;
  assign out_if.is_empty  = data_r.is_empty;
  assign out_if.max_key   = data_r.max_key;
  assign out_if.max_count = data_r.max_count;
  assign out_if.min_key   = data_r.min_key;
  assign out_if.min_count = data_r.min_count;

endmodule

>>> rtl/key_count_min_max_tracker_top.sv
`timescale 1ns / 1ps

// Keeps a table of up to 64 keys with saturating use counts. Each input word
// increments or decrements one key's count and yields one result word with a
// status, an empty flag, the key with the greatest count (ties to the greater
// key) and the key with the least count (ties to the lesser key). Keys and
// counts live in synchronous memories that are swept one entry per cycle. A
// new word is taken only once the last one has finished its sweep, its
// write-back (when the output register takes its result) and its return to
// idle. The result sits in an output register, so the next word is accepted
// while the previous result still waits to be taken.
module key_count_min_max_tracker_top (
  input logic         clk,
  input logic         rst_n,
  kcmm_in_if.sink     in_if,
  kcmm_out_if.source  out_if
);
  import kcmm_pkg::*;

  result_t res;
  logic    res_valid;
  logic    res_ready;

  kcmm_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready)
  );

  kcmm_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_i       (res),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .out_if      (out_if)
  );

endmodule

>>> verif/key_count_min_max_tracker_top_tb.sv
`timescale 1ns / 1ps

module key_count_min_max_tracker_top_tb;
  import kcmm_pkg::*;

  typedef struct {
    opcode_t op;
    field_t  key;
    bit      lit;
    result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  kcmm_in_if  in_if ();
  kcmm_out_if out_if ();

  key_count_min_max_tracker_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always #1 clk = ~clk;

  bit      tally_valid [CAPACITY];
  key_t    tally_key   [CAPACITY];
  count_t  tally_count [CAPACITY];
  result_t awaited_reports [$];
  stim_row_t directed [$];

  int errors;
  int words_sent;
  int words_seen;
  int full_drops;
  int absent_decs;
  int empty_reports;
  int peak_fill;

  function automatic stim_row_t row(opcode_t op, field_t key, bit lit, status_t st,
                                    logic empty, field_t mxk, field_t mxc,
                                    field_t mnk, field_t mnc);
    stim_row_t r;
    r.op = op;
    r.key = key;
    r.lit = lit;
    r.want.status = st;
    r.want.is_empty = empty;
    r.want.max_key = mxk;
    r.want.max_count = mxc;
    r.want.min_key = mnk;
    r.want.min_count = mnc;
    return r;
  endfunction

  function automatic void plan(stim_row_t r);
    directed.insert(directed.size(), r);
  endfunction

  function automatic int occupancy();
    int n;
    n = 0;
    for (int i = 0; i < CAPACITY; i++) n += int'(tally_valid[i]);
    return n;
  endfunction

  function automatic result_t track_update(opcode_t op, field_t key);
    result_t r;
    int      hit;
    int      spare;
    bit      any;
    hit = -1;
    spare = -1;
    any = 1'b0;
    r = '0;
    r.status = STATUS_DONE;
    for (int i = 0; i < CAPACITY; i++) begin
      if (tally_valid[i]) begin
        if (tally_key[i] == key && hit < 0) hit = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (op == OP_INC) begin
      if (hit >= 0) begin
        if (tally_count[hit] != COUNT_MAX) tally_count[hit] = tally_count[hit] + COUNT_ONE;
      end else if (spare >= 0) begin
        tally_valid[spare] = 1'b1;
        tally_key[spare] = key;
        tally_count[spare] = COUNT_ONE;
      end else begin
        r.status = STATUS_FULL;
      end
    end else begin
      if (hit >= 0) begin
        if (tally_count[hit] <= COUNT_ONE) begin
          tally_valid[hit] = 1'b0;
          tally_count[hit] = '0;
        end else begin
          tally_count[hit] = tally_count[hit] - COUNT_ONE;
        end
      end else begin
        r.status = STATUS_ABSENT;
      end
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (tally_valid[i]) begin
        if (!any) begin
          any = 1'b1;
          r.max_key = tally_key[i];
          r.max_count = tally_count[i];
          r.min_key = tally_key[i];
          r.min_count = tally_count[i];
        end else begin
          if (tally_count[i] > r.max_count ||
              (tally_count[i] == r.max_count && tally_key[i] > r.max_key)) begin
            r.max_key = tally_key[i];
            r.max_count = tally_count[i];
          end
          if (tally_count[i] < r.min_count ||
              (tally_count[i] == r.min_count && tally_key[i] < r.min_key)) begin
            r.min_key = tally_key[i];
            r.min_count = tally_count[i];
          end
        end
      end
    end
    r.is_empty = !any;
    return r;
  endfunction

  function automatic int next_idle(inout int left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(20, 120);
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic flag_mismatch(string what, field_t got, field_t want);
    errors++;
    $display("%0t: %s mismatch on word %0d: got %h, want %h", $time, what, words_seen,
             got, want);
  endtask

  int  send_left;
  bit  send_calm;

  task automatic send(opcode_t op, field_t key, bit lit, result_t want);
    result_t predicted;
    int      gap;
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.key <= key;
    do @(posedge clk); while (!in_if.ready);
    predicted = track_update(op, key);
    awaited_reports.insert(awaited_reports.size(), lit ? want : predicted);
    words_sent++;
    full_drops += int'(predicted.status == STATUS_FULL);
    absent_decs += int'(predicted.status == STATUS_ABSENT);
    empty_reports += int'(predicted.is_empty);
    if (occupancy() > peak_fill) peak_fill = occupancy();
    gap = next_idle(send_left, send_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #1500000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int  left;
    bit  calm;
    bit  held_long;
    int  stall;
    result_t got;
    result_t want;
    left = 0;
    calm = 1'b0;
    held_long = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      // Holding off here lets the result register and the sweep both fill up.
      if (words_seen == 250 && !held_long) begin
        stall = 400;
        held_long = 1'b1;
      end else begin
        stall = next_idle(left, calm);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got.status = out_if.status;
      got.is_empty = out_if.is_empty;
      got.max_key = out_if.max_key;
      got.max_count = out_if.max_count;
      got.min_key = out_if.min_key;
      got.min_count = out_if.min_count;
      if (awaited_reports.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing outstanding", $time);
      end else begin
        want = awaited_reports.pop_front();
        if (got.status !== want.status)
          flag_mismatch("status", field_t'(got.status), field_t'(want.status));
        if (got.is_empty !== want.is_empty)
          flag_mismatch("is_empty", field_t'(got.is_empty), field_t'(want.is_empty));
        if (got.max_key !== want.max_key) flag_mismatch("max_key", got.max_key, want.max_key);
        if (got.max_count !== want.max_count)
          flag_mismatch("max_count", got.max_count, want.max_count);
        if (got.min_key !== want.min_key) flag_mismatch("min_key", got.min_key, want.min_key);
        if (got.min_count !== want.min_count)
          flag_mismatch("min_count", got.min_count, want.min_count);
      end
      words_seen++;
    end
  end

  initial begin
    field_t    pool [$];
    result_t   none;
    int        pool_size;
    int        seg_len;
    int        inc_pct;
    field_t    k;
    opcode_t   op;
    none = '0;
    send_left = 0;
    send_calm = 1'b0;
    in_if.valid <= 1'b0;
    in_if.opcode <= OP_INC;
    in_if.key <= '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tally_valid[i] = 1'b0;
      tally_key[i] = '0;
      tally_count[i] = '0;
    end

    plan(row(OP_DEC, 32'h5, 1'b1, STATUS_ABSENT, 1'b1, 0, 0, 0, 0));
    plan(row(OP_INC, 32'h0, 1'b1, STATUS_DONE, 1'b0, 0, 1, 0, 1));
    plan(row(OP_INC, 32'hFFFFFFFF, 1'b1, STATUS_DONE, 1'b0, 32'hFFFFFFFF, 1, 0, 1));
    plan(row(OP_INC, 32'hFFFFFFFF, 1'b1, STATUS_DONE, 1'b0, 32'hFFFFFFFF, 2, 0, 1));
    plan(row(OP_DEC, 32'h0, 1'b1, STATUS_DONE, 1'b0, 32'hFFFFFFFF, 2,
             32'hFFFFFFFF, 2));
    plan(row(OP_DEC, 32'h12345678, 1'b1, STATUS_ABSENT, 1'b0, 32'hFFFFFFFF, 2,
             32'hFFFFFFFF, 2));
    plan(row(OP_DEC, 32'hFFFFFFFF, 1'b1, STATUS_DONE, 1'b0, 32'hFFFFFFFF, 1,
             32'hFFFFFFFF, 1));
    plan(row(OP_DEC, 32'hFFFFFFFF, 1'b1, STATUS_DONE, 1'b1, 0, 0, 0, 0));
    plan(row(OP_DEC, 32'hFFFFFFFF, 1'b1, STATUS_ABSENT, 1'b1, 0, 0, 0, 0));
    plan(row(OP_INC, 32'h7, 1'b0, STATUS_DONE, 1'b0, 0, 0, 0, 0));
    plan(row(OP_INC, 32'h3, 1'b0, STATUS_DONE, 1'b0, 0, 0, 0, 0));
    plan(row(OP_INC, 32'h9, 1'b0, STATUS_DONE, 1'b0, 0, 0, 0, 0));
    plan(row(OP_INC, 32'h3, 1'b0, STATUS_DONE, 1'b0, 0, 0, 0, 0));
    plan(row(OP_INC, 32'hAAAAAAAA, 1'b0, STATUS_DONE, 1'b0, 0, 0, 0, 0));
    plan(row(OP_INC, 32'h55555555, 1'b0, STATUS_DONE, 1'b0, 0, 0, 0, 0));
    plan(row(OP_INC, 32'h55555555, 1'b0, STATUS_DONE, 1'b0, 0, 0, 0, 0));
    plan(row(OP_DEC, 32'h7, 1'b0, STATUS_DONE, 1'b0, 0, 0, 0, 0));
    plan(row(OP_DEC, 32'h80000000, 1'b0, STATUS_DONE, 1'b0, 0, 0, 0, 0));
    plan(row(OP_INC, 32'h80000000, 1'b0, STATUS_DONE, 1'b0, 0, 0, 0, 0));
    plan(row(OP_INC, 32'h7FFFFFFF, 1'b0, STATUS_DONE, 1'b0, 0, 0, 0, 0));
    plan(row(OP_DEC, 32'h3, 1'b0, STATUS_DONE, 1'b0, 0, 0, 0, 0));
    plan(row(OP_DEC, 32'h3, 1'b0, STATUS_DONE, 1'b0, 0, 0, 0, 0));

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    foreach (directed[i]) send(directed[i].op, directed[i].key, directed[i].lit,
                               directed[i].want);

    // Fill the table, push against the full table, then drain it completely.
    while (occupancy() < CAPACITY) send(OP_INC, $urandom, 1'b0, none);
    send(OP_INC, $urandom, 1'b0, none);
    send(OP_INC, tally_key[CAPACITY/2], 1'b0, none);
    send(OP_DEC, $urandom, 1'b0, none);
    send(OP_INC, $urandom, 1'b0, none);
    for (int i = 0; i < CAPACITY; i++) begin
      while (tally_valid[i]) send(OP_DEC, tally_key[i], 1'b0, none);
    end

    while (words_sent < 1700) begin
      pool.delete();
      pool_size = ($urandom_range(0, 3) == 0) ? $urandom_range(55, 80)
                                              : $urandom_range(1, 10);
      for (int i = 0; i < pool_size; i++) begin
        case ($urandom_range(0, 7))
          0:       pool.insert(pool.size(), field_t'($urandom_range(0, 3)));
          1:       pool.insert(pool.size(), 32'hFFFFFFFF - $urandom_range(0, 3));
          default: pool.insert(pool.size(), field_t'($urandom));
        endcase
      end
      seg_len = $urandom_range(30, 150);
      inc_pct = $urandom_range(25, 90);
      for (int n = 0; n < seg_len && words_sent < 1700; n++) begin
        op = ($urandom_range(0, 99) < inc_pct) ? OP_INC : OP_DEC;
        k = ($urandom_range(0, 9) == 0) ? field_t'($urandom)
                                        : pool[$urandom_range(0, pool_size - 1)];
        send(op, k, 1'b0, none);
      end
    end

    in_if.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d words and checked %0d results; peak occupancy %0d of %0d.",
             words_sent, words_seen, peak_fill, CAPACITY);
    $display("Saw %0d table-full drops, %0d absent decrements, %0d empty-table results.",
             full_drops, absent_decs, empty_reports);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/kcmm_pkg.sv
rtl/kcmm_if.sv
rtl/kcmm_engine.sv
rtl/kcmm_out_reg.sv
rtl/key_count_min_max_tracker_top.sv
verif/key_count_min_max_tracker_top_tb.sv
